// ===== src/eased_motion_channel_top_assert.svh =====
// ----------------------------------------------------------------------------
// eased motion channel assertion macros
// concurrent checks clocked by aclk, disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef EASED_MOTION_CHANNEL_TOP_ASSERT_SVH
`define EASED_MOTION_CHANNEL_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// condition holds at every edge
`define EMC_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define EMC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define EMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define EMC_ASSERT_ALWAYS(lbl, expr, msg)
`define EMC_ASSERT_IMPL(lbl, ante, cons, msg)
`define EMC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== src/emc_pkg.sv =====
// ----------------------------------------------------------------------------
// emc_pkg
// shared constants, codes and types of the eased motion channel
// ----------------------------------------------------------------------------
`default_nettype none

package emc_pkg;

    localparam int DURATION_BITS  = 24;
    localparam int COORD_BITS     = 16;
    localparam int TIME_BITS      = 32;
    localparam int EASE_FRAC_BITS = 8;
    localparam int OP_BITS        = 3;
    localparam int PHASE_BITS     = 3;

    // serial divider covers both c*e/d and e*256/d
    localparam int DIV_W     = DURATION_BITS + COORD_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam int S_FIELD_W = TIME_BITS + 4 * COORD_BITS + DURATION_BITS;
    localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
    localparam int S_TUSER_W = OP_BITS + 1;
    localparam int M_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int M_TUSER_W = PHASE_BITS + 1;

    localparam logic [TIME_BITS-1:0] SPAN_MAX =
        TIME_BITS'((33'd1 << DURATION_BITS) - 33'd1);

    typedef enum logic [OP_BITS-1:0] {
        OP_SET_POS = 3'd0,
        OP_START   = 3'd1,
        OP_PAUSE   = 3'd2,
        OP_RESUME  = 3'd3,
        OP_STOP    = 3'd4,
        OP_REVERSE = 3'd5,
        OP_UPDATE  = 3'd6
    } op_t;

    typedef enum logic [PHASE_BITS-1:0] {
        PH_IDLE      = 3'd0,
        PH_PLAYING   = 3'd1,
        PH_PAUSED    = 3'd2,
        PH_REVERSING = 3'd3,
        PH_FINISHED  = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_PREP,
        CS_CHECK,
        CS_LAUNCH,
        CS_DIV,
        CS_SQR,
        CS_SCALE,
        CS_COMMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic check;
        logic launch;
        logic sqr;
        logic scale;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic quad;
        logic div_busy;
    } dp_status_t;

    typedef struct packed {
        logic [OP_BITS-1:0]          op;
        logic [TIME_BITS-1:0]        now_ms;
        logic signed [COORD_BITS-1:0] from_x;
        logic signed [COORD_BITS-1:0] from_y;
        logic signed [COORD_BITS-1:0] to_x;
        logic signed [COORD_BITS-1:0] to_y;
        logic [DURATION_BITS-1:0]    span_ms;
        logic                        ease_kind;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        phase_t                      phase;
        logic                        done_pulse;
    } out_item_t;

endpackage

`default_nettype wire

// ===== src/emc_divider.sv =====
// ----------------------------------------------------------------------------
// emc_divider
// two-lane restoring divider, one quotient bit per lane and cycle,
// both lanes share the divisor and the step counter
// ----------------------------------------------------------------------------
`default_nettype none

module emc_divider
    import emc_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic [DIV_W-1:0]         dividend_a,
    input  wire logic [DIV_W-1:0]         dividend_b,
    input  wire logic [DURATION_BITS-1:0] divisor,
    output logic                          busy,
    output logic [DIV_W-1:0]              quot_a,
    output logic [DIV_W-1:0]              quot_b
);

    logic [DURATION_BITS-1:0] rem_reg [2];
    logic [DURATION_BITS-1:0] rem_next [2];
    logic [DIV_W-1:0]         shf_reg [2];
    logic [DIV_W-1:0]         shf_next [2];
    logic [DIV_W-1:0]         dvd [2];
    logic [DURATION_BITS:0]   trial [2];
    logic [DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;

    assign dvd[0] = dividend_a;
    assign dvd[1] = dividend_b;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            trial[i]    = {rem_reg[i], shf_reg[i][DIV_W-1]};
            rem_next[i] = rem_reg[i];
            shf_next[i] = shf_reg[i];
            if (start) begin
                rem_next[i] = '0;
                shf_next[i] = dvd[i];
            end else if (busy_reg) begin
                // dividend bits shift out at the top, quotient bits in at the bottom
                if (trial[i] >= {1'b0, divisor}) begin
                    rem_next[i] = DURATION_BITS'(trial[i] - {1'b0, divisor});
                    shf_next[i] = {shf_reg[i][DIV_W-2:0], 1'b1};
                end else begin
                    rem_next[i] = trial[i][DURATION_BITS-1:0];
                    shf_next[i] = {shf_reg[i][DIV_W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            cnt_next  = DIV_CNT_W'(DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 2; i++) begin
            rem_reg[i] <= rem_next[i];
            shf_reg[i] <= shf_next[i];
        end
    end

    assign busy   = busy_reg;
    assign quot_a = shf_reg[0];
    assign quot_b = shf_reg[1];

endmodule

`default_nettype wire

// ===== src/emc_datapath.sv =====
// ----------------------------------------------------------------------------
// emc_datapath
// channel state, elapsed time, easing arithmetic and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module emc_datapath
    import emc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire ctrl_cmd_t cmd,
    input  wire in_item_t  item,
    output dp_status_t     status,
    output out_item_t      result
);

    localparam int CW = COORD_BITS;
    localparam int DB = DURATION_BITS;
    localparam int F  = EASE_FRAC_BITS;

    // channel state
    phase_t                 phase_reg, phase_next;
    logic [TIME_BITS-1:0]   origin_time_reg, origin_time_next;
    logic [DB-1:0]          span_reg, span_next;
    logic [CW-1:0]          begin_x_reg, begin_x_next, begin_y_reg, begin_y_next;
    logic [CW-1:0]          target_x_reg, target_x_next, target_y_reg, target_y_next;
    logic [CW-1:0]          now_x_reg, now_x_next, now_y_reg, now_y_next;
    logic                   ease_reg, ease_next;
    logic [TIME_BITS-1:0]   held_elapsed_reg, held_elapsed_next;
    logic                   done_next;

    // working registers
    in_item_t               item_reg;
    logic [TIME_BITS-1:0]   el_reg;
    logic [CW-1:0]          mag_x_reg, mag_y_reg;
    logic                   neg_x_reg, neg_y_reg;
    logic [DIV_W-1:0]       prod_x_reg, prod_y_reg;
    logic [2*F-1:0]         nn_reg;
    logic [CW+F:0]          scale_x_reg, scale_y_reg;
    out_item_t              result_reg;

    logic [CW:0]            diff_x, diff_y, ndiff_x, ndiff_y;
    logic                   upd_active, early;
    logic [DIV_W-1:0]       div_a;
    logic [DIV_W-1:0]       quot_a, quot_b;
    logic                   div_busy;
    logic [F-1:0]           ease_n;
    logic [F:0]             ease_p;
    logic [CW-1:0]          q_x, q_y, eased_x, eased_y;
    logic [TIME_BITS-1:0]   rev_span;

    // signed change of one coordinate, one bit wider than the coordinate
    assign diff_x  = {target_x_reg[CW-1], target_x_reg} - {begin_x_reg[CW-1], begin_x_reg};
    assign diff_y  = {target_y_reg[CW-1], target_y_reg} - {begin_y_reg[CW-1], begin_y_reg};
    assign ndiff_x = -diff_x;
    assign ndiff_y = -diff_y;

    assign upd_active = (item_reg.op == OP_UPDATE) &&
                        ((phase_reg == PH_PLAYING) || (phase_reg == PH_REVERSING));
    assign early      = el_reg < TIME_BITS'(span_reg);

    assign status.need_div = upd_active && early;
    assign status.quad     = ease_reg;
    assign status.div_busy = div_busy;

    // quadratic: lane a divides e*256 by d, lane b is unused
    assign div_a = ease_reg ? DIV_W'({el_reg[DB-1:0], {F{1'b0}}}) : prod_x_reg;

    emc_divider u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (cmd.launch),
        .dividend_a (div_a),
        .dividend_b (prod_y_reg),
        .divisor    (span_reg),
        .busy       (div_busy),
        .quot_a     (quot_a),
        .quot_b     (quot_b)
    );

    assign ease_n = quot_a[F-1:0];
    // p = 2n - n*n/256, at most 256
    assign ease_p = {ease_n, 1'b0} - {1'b0, nn_reg[2*F-1:F]};

    assign q_x = ease_reg ? scale_x_reg[CW+F-1:F] : quot_a[CW-1:0];
    assign q_y = ease_reg ? scale_y_reg[CW+F-1:F] : quot_b[CW-1:0];

    // offset magnitude never exceeds the change, so modular add gives the point
    assign eased_x = neg_x_reg ? begin_x_reg - q_x : begin_x_reg + q_x;
    assign eased_y = neg_y_reg ? begin_y_reg - q_y : begin_y_reg + q_y;

    assign rev_span = (phase_reg == PH_FINISHED) ? TIME_BITS'(span_reg) :
                      ((el_reg > SPAN_MAX) ? SPAN_MAX : el_reg);

    always_comb begin
        phase_next        = phase_reg;
        origin_time_next  = origin_time_reg;
        span_next         = span_reg;
        begin_x_next      = begin_x_reg;
        begin_y_next      = begin_y_reg;
        target_x_next     = target_x_reg;
        target_y_next     = target_y_reg;
        now_x_next        = now_x_reg;
        now_y_next        = now_y_reg;
        ease_next         = ease_reg;
        held_elapsed_next = held_elapsed_reg;
        done_next         = 1'b0;
        case (item_reg.op)
            OP_SET_POS: begin
                now_x_next    = item_reg.from_x;
                now_y_next    = item_reg.from_y;
                begin_x_next  = item_reg.from_x;
                begin_y_next  = item_reg.from_y;
                target_x_next = item_reg.from_x;
                target_y_next = item_reg.from_y;
                phase_next    = PH_IDLE;
            end
            OP_START: begin
                phase_next       = PH_PLAYING;
                origin_time_next = item_reg.now_ms;
                span_next        = item_reg.span_ms;
                begin_x_next     = item_reg.from_x;
                begin_y_next     = item_reg.from_y;
                now_x_next       = item_reg.from_x;
                now_y_next       = item_reg.from_y;
                target_x_next    = item_reg.to_x;
                target_y_next    = item_reg.to_y;
                ease_next        = item_reg.ease_kind;
            end
            OP_PAUSE: begin
                if (phase_reg == PH_PLAYING) begin
                    phase_next        = PH_PAUSED;
                    held_elapsed_next = el_reg;
                end
            end
            OP_RESUME: begin
                if (phase_reg == PH_PAUSED) begin
                    phase_next       = PH_PLAYING;
                    origin_time_next = item_reg.now_ms - held_elapsed_reg;
                end
            end
            OP_STOP: begin
                phase_next = PH_IDLE;
            end
            OP_REVERSE: begin
                if (phase_reg != PH_REVERSING) begin
                    target_x_next    = begin_x_reg;
                    target_y_next    = begin_y_reg;
                    begin_x_next     = now_x_reg;
                    begin_y_next     = now_y_reg;
                    origin_time_next = item_reg.now_ms;
                    span_next        = rev_span[DB-1:0];
                    phase_next       = PH_REVERSING;
                end
            end
            OP_UPDATE: begin
                if (upd_active) begin
                    if (early) begin
                        now_x_next = eased_x;
                        now_y_next = eased_y;
                    end else begin
                        now_x_next = target_x_reg;
                        now_y_next = target_y_reg;
                        phase_next = PH_FINISHED;
                        done_next  = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            origin_time_reg  <= '0;
            span_reg         <= '0;
            begin_x_reg      <= '0;
            begin_y_reg      <= '0;
            target_x_reg     <= '0;
            target_y_reg     <= '0;
            now_x_reg        <= '0;
            now_y_reg        <= '0;
            ease_reg         <= 1'b1;
            held_elapsed_reg <= '0;
        end else if (cmd.commit) begin
            phase_reg        <= phase_next;
            origin_time_reg  <= origin_time_next;
            span_reg         <= span_next;
            begin_x_reg      <= begin_x_next;
            begin_y_reg      <= begin_y_next;
            target_x_reg     <= target_x_next;
            target_y_reg     <= target_y_next;
            now_x_reg        <= now_x_next;
            now_y_reg        <= now_y_next;
            ease_reg         <= ease_next;
            held_elapsed_reg <= held_elapsed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= item;
        end
        if (cmd.prep) begin
            el_reg    <= item_reg.now_ms - origin_time_reg;
            neg_x_reg <= diff_x[CW];
            neg_y_reg <= diff_y[CW];
            mag_x_reg <= diff_x[CW] ? ndiff_x[CW-1:0] : diff_x[CW-1:0];
            mag_y_reg <= diff_y[CW] ? ndiff_y[CW-1:0] : diff_y[CW-1:0];
        end
        if (cmd.check) begin
            prod_x_reg <= DIV_W'(mag_x_reg) * DIV_W'(el_reg[DB-1:0]);
            prod_y_reg <= DIV_W'(mag_y_reg) * DIV_W'(el_reg[DB-1:0]);
        end
        if (cmd.sqr) begin
            nn_reg <= (2*F)'(ease_n) * (2*F)'(ease_n);
        end
        if (cmd.scale) begin
            scale_x_reg <= (CW+F+1)'(mag_x_reg) * (CW+F+1)'(ease_p);
            scale_y_reg <= (CW+F+1)'(mag_y_reg) * (CW+F+1)'(ease_p);
        end
        if (cmd.commit) begin
            result_reg.pos_x      <= now_x_next;
            result_reg.pos_y      <= now_y_next;
            result_reg.phase      <= phase_next;
            result_reg.done_pulse <= done_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== src/emc_ctrl.sv =====
// ----------------------------------------------------------------------------
// emc_ctrl
// sequencer for one item at a time and the result valid flag
// ----------------------------------------------------------------------------
`default_nettype none

module emc_ctrl
    import emc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE: begin
                if (s_tvalid) begin
                    state_next = CS_PREP;
                end
            end
            CS_PREP: begin
                state_next = CS_CHECK;
            end
            CS_CHECK: begin
                state_next = status.need_div ? CS_LAUNCH : CS_COMMIT;
            end
            CS_LAUNCH: begin
                state_next = CS_DIV;
            end
            CS_DIV: begin
                if (!status.div_busy) begin
                    state_next = status.quad ? CS_SQR : CS_COMMIT;
                end
            end
            CS_SQR: begin
                state_next = CS_SCALE;
            end
            CS_SCALE: begin
                state_next = CS_COMMIT;
            end
            CS_COMMIT: begin
                // hold until the result register has room
                if (out_free) begin
                    state_next = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready   = (state_reg == CS_IDLE);
        cmd.load   = (state_reg == CS_IDLE) && s_tvalid;
        cmd.prep   = (state_reg == CS_PREP);
        cmd.check  = (state_reg == CS_CHECK);
        cmd.launch = (state_reg == CS_LAUNCH);
        cmd.sqr    = (state_reg == CS_SQR);
        cmd.scale  = (state_reg == CS_SCALE);
        cmd.commit = (state_reg == CS_COMMIT) && out_free;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CS_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire

// ===== src/eased_motion_channel_top.sv =====
// ----------------------------------------------------------------------------
// eased_motion_channel_top
// one x,y animation channel with linear or quadratic ease-out easing
// ----------------------------------------------------------------------------
// every op but a moving update passes through the prep, check and commit states;
// a moving update adds launch and the divider wait (linear), plus square and scale
//   (quadratic), paced by the 40-step serial divider that both coordinates share
// one item in flight, the next transfer is taken the cycle after the result is registered,
//   and the commit waits while the result register still holds an untaken result
// reset: synchronous active low, clears the channel state at once, no clearing pass
`default_nettype none

`include "eased_motion_channel_top_assert.svh"

module eased_motion_channel_top
    import emc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // now_ms, from_x, from_y, to_x, to_y, span_ms
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // op, ease_kind
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // pos_x, pos_y
    output logic [M_TDATA_W-1:0]      m_tdata,
    // phase, done_pulse
    output logic [M_TUSER_W-1:0]      m_tuser
);

    localparam int FX_LO = TIME_BITS;
    localparam int FY_LO = FX_LO + COORD_BITS;
    localparam int TX_LO = FY_LO + COORD_BITS;
    localparam int TY_LO = TX_LO + COORD_BITS;
    localparam int SP_LO = TY_LO + COORD_BITS;

    in_item_t   item;
    out_item_t  result;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign item.op        = s_tuser[OP_BITS-1:0];
    assign item.ease_kind = s_tuser[OP_BITS];
    assign item.now_ms    = s_tdata[TIME_BITS-1:0];
    assign item.from_x    = s_tdata[FX_LO +: COORD_BITS];
    assign item.from_y    = s_tdata[FY_LO +: COORD_BITS];
    assign item.to_x      = s_tdata[TX_LO +: COORD_BITS];
    assign item.to_y      = s_tdata[TY_LO +: COORD_BITS];
    assign item.span_ms   = s_tdata[SP_LO +: DURATION_BITS];

    emc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    emc_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .item    (item),
        .status  (status),
        .result  (result)
    );

    assign m_tdata = M_TDATA_W'({result.pos_y, result.pos_x});
    assign m_tuser = {result.done_pulse, result.phase};

    // a commit never overwrites a result that is still waiting
    `EMC_ASSERT_IMPL(a_commit_slot_free, cmd.commit, !m_tvalid || m_tready, "commit over pending result")
    // the divider is idle whenever a new item can be taken
    `EMC_ASSERT_IMPL(a_accept_div_idle, s_tvalid && s_tready, !status.div_busy, "divider busy at accept")
    // a single item in flight
    `EMC_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "ready right after transfer")
    // the finish pulse only comes with the finished phase
    `EMC_ASSERT_IMPL(a_done_finished, m_tvalid && m_tuser[PHASE_BITS], m_tuser[PHASE_BITS-1:0] == PH_FINISHED, "done without finished phase")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// eased motion channel testbench
// drives opcode/time commands over the input stream and checks every returned
// point, phase and finish pulse against a cycle-free model of the channel
// ----------------------------------------------------------------------------
import emc_pkg::*;

class motion_scoreboard;

    // channel state mirrored from the block
    phase_t                       phase;
    logic [TIME_BITS-1:0]         origin;
    logic [DURATION_BITS-1:0]     span;
    logic signed [COORD_BITS-1:0] start_x, start_y, end_x, end_y, cur_x, cur_y;
    logic                         quad;
    logic [TIME_BITS-1:0]         held;

    out_item_t expected_points[$];
    int        mismatches;
    int        checked;
    int        moving_updates;
    int        finishes;
    int        reverses;

    function new();
        phase          = PH_IDLE;
        origin         = '0;
        span           = '0;
        start_x        = '0;
        start_y        = '0;
        end_x          = '0;
        end_y          = '0;
        cur_x          = '0;
        cur_y          = '0;
        quad           = 1'b1;
        held           = '0;
        mismatches     = 0;
        checked        = 0;
        moving_updates = 0;
        finishes       = 0;
        reverses       = 0;
    endfunction

    // offset of the eased curve for elapsed e (e < d) and total change c
    function longint ease_offset(logic [TIME_BITS-1:0] e, longint c);
        longint el_l;
        longint d_l;
        longint n;
        longint p;
        el_l = longint'(e);
        d_l  = longint'(span);
        if (!quad)
            return (c * el_l) / d_l;
        n = (el_l * 256) / d_l;
        p = 2 * n - ((n * n) >>> 8);
        return (c * p) / 256;
    endfunction

    function void note_command(in_item_t it);
        logic [TIME_BITS-1:0] el;
        logic [TIME_BITS-1:0] dur;
        logic                 done;
        out_item_t            res;
        el   = it.now_ms - origin;
        done = 1'b0;
        case (it.op)
            OP_SET_POS: begin
                cur_x   = it.from_x;
                start_x = it.from_x;
                end_x   = it.from_x;
                cur_y   = it.from_y;
                start_y = it.from_y;
                end_y   = it.from_y;
                phase   = PH_IDLE;
            end
            OP_START: begin
                phase   = PH_PLAYING;
                origin  = it.now_ms;
                span    = it.span_ms;
                start_x = it.from_x;
                cur_x   = it.from_x;
                start_y = it.from_y;
                cur_y   = it.from_y;
                end_x   = it.to_x;
                end_y   = it.to_y;
                quad    = it.ease_kind;
            end
            OP_PAUSE: begin
                if (phase == PH_PLAYING) begin
                    phase = PH_PAUSED;
                    held  = el;
                end
            end
            OP_RESUME: begin
                if (phase == PH_PAUSED) begin
                    phase  = PH_PLAYING;
                    origin = it.now_ms - held;
                end
            end
            OP_STOP: begin
                phase = PH_IDLE;
            end
            OP_REVERSE: begin
                if (phase != PH_REVERSING) begin
                    dur = (phase == PH_FINISHED) ? TIME_BITS'(span) : el;
                    if (dur > SPAN_MAX)
                        dur = SPAN_MAX;
                    end_x   = start_x;
                    end_y   = start_y;
                    start_x = cur_x;
                    start_y = cur_y;
                    origin  = it.now_ms;
                    span    = dur[DURATION_BITS-1:0];
                    phase   = PH_REVERSING;
                    reverses++;
                end
            end
            OP_UPDATE: begin
                if (phase == PH_PLAYING || phase == PH_REVERSING) begin
                    if (el >= TIME_BITS'(span)) begin
                        cur_x = end_x;
                        cur_y = end_y;
                        phase = PH_FINISHED;
                        done  = 1'b1;
                        finishes++;
                    end else begin
                        cur_x = COORD_BITS'(longint'(start_x) +
                            ease_offset(el, longint'(end_x) - longint'(start_x)));
                        cur_y = COORD_BITS'(longint'(start_y) +
                            ease_offset(el, longint'(end_y) - longint'(start_y)));
                        moving_updates++;
                    end
                end
            end
            default: ;
        endcase
        res.pos_x      = cur_x;
        res.pos_y      = cur_y;
        res.phase      = phase;
        res.done_pulse = done;
        expected_points.push_back(res);
    endfunction

    function void check_sample(out_item_t got);
        out_item_t want;
        if (expected_points.size() == 0) begin
            $error("result transfer with no command outstanding: x=%0d y=%0d phase=%0d",
                got.pos_x, got.pos_y, got.phase);
            mismatches++;
            return;
        end
        want = expected_points.pop_front();
        checked++;
        if (got.pos_x !== want.pos_x) begin
            $error("pos_x: expected %0d, actual %0d", want.pos_x, got.pos_x);
            mismatches++;
        end
        if (got.pos_y !== want.pos_y) begin
            $error("pos_y: expected %0d, actual %0d", want.pos_y, got.pos_y);
            mismatches++;
        end
        if (got.phase !== want.phase) begin
            $error("phase: expected %0d, actual %0d", want.phase, got.phase);
            mismatches++;
        end
        if (got.done_pulse !== want.done_pulse) begin
            $error("done_pulse: expected %0d, actual %0d", want.done_pulse,
                got.done_pulse);
            mismatches++;
        end
    endfunction

    function int pending();
        return expected_points.size();
    endfunction

endclass

module tb;

    localparam int             ITEM_TARGET = 1650;
    localparam int             CALM_ITEMS  = 150;
    localparam logic [OP_BITS-1:0] OP_UNUSED = 3'd7;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    motion_scoreboard     sb;
    logic                 quiet = 1'b0;
    int                   issued = 0;
    int                   ready_hold = 0;
    logic [TIME_BITS-1:0] clock_ms;

    eased_motion_channel_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 aclk = ~aclk;

    // receiver back-pressure in bursts of random length, none started in the quiet tail
    always @(negedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            m_tready   <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            ready_hold <= $urandom_range(0, 8);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // transfer monitor on both channels
    always @(posedge aclk) begin
        in_item_t  cmd;
        out_item_t res;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                cmd.now_ms    = s_tdata[31:0];
                cmd.from_x    = s_tdata[47:32];
                cmd.from_y    = s_tdata[63:48];
                cmd.to_x      = s_tdata[79:64];
                cmd.to_y      = s_tdata[95:80];
                cmd.span_ms   = s_tdata[119:96];
                cmd.op        = s_tuser[2:0];
                cmd.ease_kind = s_tuser[3];
                sb.note_command(cmd);
            end
            if (m_tvalid && m_tready) begin
                res.pos_x      = m_tdata[15:0];
                res.pos_y      = m_tdata[31:16];
                res.phase      = phase_t'(m_tuser[2:0]);
                res.done_pulse = m_tuser[3];
                sb.check_sample(res);
            end
        end
    end

    task automatic push(input logic [OP_BITS-1:0] op, input logic [TIME_BITS-1:0] now,
                        input logic [COORD_BITS-1:0] fx, input logic [COORD_BITS-1:0] fy,
                        input logic [COORD_BITS-1:0] tx, input logic [COORD_BITS-1:0] ty,
                        input logic [DURATION_BITS-1:0] span, input logic ease);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {span, ty, tx, fy, fx, now};
        s_tuser  <= {ease, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        issued++;
        if (issued >= ITEM_TARGET - CALM_ITEMS)
            quiet = 1'b1;
    endtask

    // hold the sender off until every outstanding result is back
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [COORD_BITS-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return COORD_BITS'($urandom_range(0, 200));
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [DURATION_BITS-1:0] pick_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return DURATION_BITS'($urandom_range(1, 3000));
        else if (r < 85)
            return DURATION_BITS'($urandom_range(3001, 200000));
        else if (r < 95)
            return DURATION_BITS'($urandom);
        return '0;
    endfunction

    function automatic logic [COORD_BITS-1:0] rnd_coord();
        return COORD_BITS'($urandom);
    endfunction

    function automatic logic [DURATION_BITS-1:0] rnd_span();
        return DURATION_BITS'($urandom);
    endfunction

    function automatic logic rnd_bit();
        return 1'($urandom);
    endfunction

    // op whose payload fields are ignored, filled with noise
    task automatic push_op(input logic [OP_BITS-1:0] op, input logic [TIME_BITS-1:0] now);
        push(op, now, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_span(),
             rnd_bit());
    endtask

    task automatic push_noise();
        push_op(OP_BITS'($urandom), $urandom);
    endtask

    // an optional set-position and a start, then a run of updates and the occasional other op
    task automatic run_motion();
        logic [DURATION_BITS-1:0] span;
        logic [TIME_BITS-1:0]     step_max;
        int                       steps;
        int                       r;
        span     = pick_span();
        step_max = TIME_BITS'(span) / 5 + 2;
        if ($urandom_range(0, 3) == 0)
            push(OP_SET_POS, clock_ms, pick_coord(), pick_coord(), rnd_coord(), rnd_coord(),
                 rnd_span(), rnd_bit());
        push(OP_START, clock_ms, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
             span, rnd_bit());
        steps = $urandom_range(3, 16);
        repeat (steps) begin
            clock_ms = clock_ms + $urandom_range(0, step_max);
            r = $urandom_range(0, 99);
            if (r < 68)
                push_op(OP_UPDATE, clock_ms);
            else if (r < 76)
                push_op(OP_PAUSE, clock_ms);
            else if (r < 84)
                push_op(OP_RESUME, clock_ms);
            else if (r < 91)
                push_op(OP_REVERSE, clock_ms);
            else if (r < 94)
                push_op(OP_STOP, clock_ms);
            else if (r < 96)
                push(OP_SET_POS, clock_ms, pick_coord(), pick_coord(), rnd_coord(),
                     rnd_coord(), rnd_span(), rnd_bit());
            else if (r < 98)
                push_op(OP_UNUSED, clock_ms);
            else
                push(OP_START, clock_ms, pick_coord(), pick_coord(), pick_coord(),
                     pick_coord(), span, rnd_bit());
        end
    endtask

    initial begin
        logic [TIME_BITS-1:0] t;
        logic                 mid_drained;
        sb          = new();
        mid_drained = 1'b0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: wrong-phase ops, every op, wrap, zero span, saturation
        t = 32'h0000_1000;
        push_op(OP_UPDATE, 32'd0);
        push_op(OP_PAUSE, 32'd5);
        push_op(OP_RESUME, 32'd6);
        push(OP_SET_POS, 32'd10, 16'h7fff, 16'h8000, rnd_coord(), rnd_coord(), rnd_span(),
             1'b1);
        push(OP_START, t, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 24'd1000, 1'b0);
        push_op(OP_UPDATE, t + 250);
        push_op(OP_PAUSE, t + 300);
        push_op(OP_PAUSE, t + 310);
        push_op(OP_UPDATE, t + 400);
        push_op(OP_RESUME, t + 5000);
        push_op(OP_UPDATE, t + 5500);
        push_op(OP_REVERSE, t + 5600);
        push_op(OP_REVERSE, t + 5610);
        push_op(OP_UPDATE, t + 6000);
        push_op(OP_UPDATE, t + 6500);
        push_op(OP_UPDATE, t + 6600);
        push_op(OP_REVERSE, t + 6700);
        push_op(OP_STOP, t + 6800);
        // zero span finishes on the first update
        push(OP_START, 32'hffff_ff00, 16'd100, -16'sd100, -16'sd5000, 16'd5000, 24'd0, 1'b1);
        push_op(OP_UPDATE, 32'hffff_ff00);
        // full-scale span and elapsed time across the 32-bit wrap
        push(OP_START, 32'hffff_fff0, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
             24'hffffff, 1'b1);
        push_op(OP_UPDATE, 32'h0000_0100);
        push_op(OP_UNUSED, 32'h0000_0200);
        push_op(OP_UPDATE, 32'h00f0_0000);
        // reverse from idle with an elapsed time too wide for the span register
        push_op(OP_STOP, 32'h7000_0000);
        push_op(OP_REVERSE, 32'hf000_0000);
        push_op(OP_PAUSE, 32'hf000_0010);
        push_op(OP_UPDATE, 32'hf080_0000);
        // reverse out of a pause
        push(OP_START, 32'd50, -16'sd300, 16'd300, 16'd900, -16'sd900, 24'd400, 1'b1);
        push_op(OP_PAUSE, 32'd150);
        push_op(OP_REVERSE, 32'd700);
        drain();

        clock_ms = $urandom;
        while (issued < ITEM_TARGET) begin
            if ($urandom_range(0, 99) < 85)
                run_motion();
            else
                push_noise();
            if (!mid_drained && issued >= ITEM_TARGET / 2) begin
                drain();
                mid_drained = 1'b1;
            end
        end

        drain();
        repeat (60) @(posedge aclk);
        $display("covered %0d transfers: %0d moving updates, %0d finishes, %0d reverses",
            sb.checked, sb.moving_updates, sb.finishes, sb.reverses);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("eased_motion_channel_top verification clean");
        end else begin
            $display("%0d mismatches, %0d results outstanding", sb.mismatches,
                sb.pending());
            $display("eased_motion_channel_top verification failed");
        end
        $finish;
    end

    initial begin
        #16_000_000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("eased_motion_channel_top verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/emc_pkg.sv
src/emc_divider.sv
src/emc_datapath.sv
src/emc_ctrl.sv
src/eased_motion_channel_top.sv
tb/sv/tb.sv
